// ===== rtl/rbf_pkg.sv =====
`timescale 1ns / 1ps

package rbf_pkg;

  // fixed field widths of the item ports
  localparam int DATA_FIELD_W  = 32;
  localparam int COUNT_FIELD_W = 8;
  localparam int OCC_FIELD_W   = 8;

  typedef enum logic [2:0] {
    OP_PUT      = 3'd0,
    OP_GET      = 3'd1,
    OP_ADV_HEAD = 3'd2,
    OP_ADV_TAIL = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  // per-operation outcome from the pointer control
  typedef struct packed {
    status_t                  status;
    logic [OCC_FIELD_W-1:0]   index;
    logic                     data_ok;
    logic                     wr_en;
    logic                     rd_en;
  } ctrl_res_t;

endpackage

// ===== rtl/rbf_mem.sv =====
`timescale 1ns / 1ps

module rbf_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rbf_ctrl.sv =====
`timescale 1ns / 1ps

module rbf_ctrl #(
  parameter int CAPACITY = 255,
  localparam int SLOT_COUNT = CAPACITY + 1,
  localparam int PW = $clog2(SLOT_COUNT)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  fire,
  input  rbf_pkg::op_t                          op,
  input  logic [rbf_pkg::COUNT_FIELD_W-1:0]     count,
  output rbf_pkg::ctrl_res_t                    res,
  output logic [PW-1:0]                         wr_addr,
  output logic [PW-1:0]                         rd_addr,
  output logic [rbf_pkg::OCC_FIELD_W-1:0]       used,
  output logic [rbf_pkg::OCC_FIELD_W-1:0]       available,
  output logic [rbf_pkg::OCC_FIELD_W-1:0]       linear_space
);

  import rbf_pkg::*;

  localparam logic [PW:0]   SLOTS    = (PW + 1)'(SLOT_COUNT);
  localparam logic [PW:0]   CAP_W    = (PW + 1)'(CAPACITY);
  localparam logic [PW-1:0] LAST_IDX = PW'(CAPACITY);
  localparam int            CW       = (PW + 1 > COUNT_FIELD_W) ? PW + 1 : COUNT_FIELD_W;

  logic [PW-1:0] head_ptr, head_ptr_next;
  logic [PW-1:0] tail_ptr, tail_ptr_next;
  logic [PW-1:0] head_inc, tail_inc;
  logic [PW:0]   used_now, free_now;
  logic          full, empty;

  function automatic logic [PW:0] ring_sub(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      d = d + SLOTS;
    end
    return d;
  endfunction

  // only used when count is within free or used space, so sum < 2 * slots
  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a,
                                             input logic [COUNT_FIELD_W-1:0] c);
    logic [PW:0] s;
    s = {1'b0, a} + (PW + 1)'(c);
    if (s >= SLOTS) begin
      s = s - SLOTS;
    end
    return s[PW-1:0];
  endfunction

  assign head_inc = (head_ptr == LAST_IDX) ? '0 : head_ptr + 1'b1;
  assign tail_inc = (tail_ptr == LAST_IDX) ? '0 : tail_ptr + 1'b1;
  assign full     = (head_inc == tail_ptr);
  assign empty    = (head_ptr == tail_ptr);
  assign used_now = ring_sub(head_ptr, tail_ptr);
  assign free_now = CAP_W - used_now;

  always_comb begin
    head_ptr_next = head_ptr;
    tail_ptr_next = tail_ptr;
    res.status    = ST_OK;
    res.index     = '0;
    res.data_ok   = 1'b0;
    res.wr_en     = 1'b0;
    res.rd_en     = 1'b0;
    unique case (op)
      OP_PUT: begin
        res.index = OCC_FIELD_W'(head_ptr);
        if (full) begin
          res.status = ST_FULL;
        end else begin
          res.wr_en     = 1'b1;
          head_ptr_next = head_inc;
        end
      end
      OP_GET: begin
        res.index = OCC_FIELD_W'(tail_ptr);
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.rd_en     = 1'b1;
          res.data_ok   = 1'b1;
          tail_ptr_next = tail_inc;
        end
      end
      OP_ADV_HEAD: begin
        res.index = OCC_FIELD_W'(head_ptr);
        if (CW'(free_now) < CW'(count)) begin
          res.status = ST_REFUSED;
        end else begin
          head_ptr_next = ring_add(head_ptr, count);
        end
      end
      OP_ADV_TAIL: begin
        if (CW'(used_now) < CW'(count)) begin
          res.status = ST_REFUSED;
        end else begin
          tail_ptr_next = ring_add(tail_ptr, count);
        end
        res.index = OCC_FIELD_W'(tail_ptr_next);
      end
      OP_CLEAR: begin
        head_ptr_next = tail_ptr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
    end else if (fire) begin
      head_ptr <= head_ptr_next;
      tail_ptr <= tail_ptr_next;
    end
  end

  assign wr_addr = head_ptr;
  assign rd_addr = tail_ptr;

  // occupancy straight from the pointers
  assign used      = OCC_FIELD_W'(used_now);
  assign available = OCC_FIELD_W'(free_now);

  always_comb begin
    if (head_ptr < tail_ptr) begin
      linear_space = OCC_FIELD_W'(free_now);
    end else if (tail_ptr == '0) begin
      linear_space = OCC_FIELD_W'(CAP_W - {1'b0, head_ptr});
    end else begin
      linear_space = OCC_FIELD_W'(SLOTS - {1'b0, head_ptr});
    end
  end

endmodule

// ===== rtl/ring_buffer_fifo_unit.sv =====
// ring buffer fifo, one slot kept open: CAPACITY words in CAPACITY+1 slots
//
// input channel: op, data_in, count with in_valid / in_stall. a transfer
// happens on a rising edge with in_valid high and in_stall low. ops are put,
// get, advance head by count, advance tail by count and clear
// output channel: status, data_out, index, used, available, linear_space with
// out_valid / out_stall; exactly one result per input transfer, in order
//
// an item is taken into the input register, where the pointer logic and the
// slot memory act on it, and its result is taken into the output register
// when the input stage moves on; out_valid then rises and the result transfer
// follows once out_stall is low
// throughput: one item per cycle while out_stall is low, set by the single
// pass through pointer logic and the one write / one read port of slot memory
// used, available and linear_space are taken from the pointer registers,
// which always hold the state left by the result on show
//
// reset: pointers to zero (empty buffer), both stages emptied; slot contents
// are not cleared, and a get after advance head can read a slot no put wrote
// out_stall holds a valid result in the output register; an item in the
// input register holds too and in_stall rises, so at most one waits per stage
`timescale 1ns / 1ps

module ring_buffer_fifo_unit #(
  parameter int CAPACITY   = 255,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          op,
  input  logic [rbf_pkg::DATA_FIELD_W-1:0]    data_in,
  input  logic [rbf_pkg::COUNT_FIELD_W-1:0]   count,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [rbf_pkg::DATA_FIELD_W-1:0]    data_out,
  output logic [rbf_pkg::OCC_FIELD_W-1:0]     index,
  output logic [rbf_pkg::OCC_FIELD_W-1:0]     used,
  output logic [rbf_pkg::OCC_FIELD_W-1:0]     available,
  output logic [rbf_pkg::OCC_FIELD_W-1:0]     linear_space
);

  import rbf_pkg::*;

  localparam int SLOT_COUNT = CAPACITY + 1;
  localparam int PW         = $clog2(SLOT_COUNT);

  // input register
  logic                     s1_valid;
  op_t                      s1_op;
  logic [DATA_FIELD_W-1:0]  s1_data;
  logic [COUNT_FIELD_W-1:0] s1_count;
  logic                     s1_adv;

  // output register
  logic                     res_valid;
  status_t                  res_status;
  logic [OCC_FIELD_W-1:0]   res_index;
  logic                     res_data_ok;

  ctrl_res_t                ctrl_res;
  logic [PW-1:0]            wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0]    rd_data;

  // the input stage moves on whenever the output register is free or emptying
  assign s1_adv   = s1_valid && (!res_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_op    <= op_t'(op);
      s1_data  <= data_in;
      s1_count <= count;
    end
  end

  rbf_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .fire         (s1_adv),
    .op           (s1_op),
    .count        (s1_count),
    .res          (ctrl_res),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr),
    .used         (used),
    .available    (available),
    .linear_space (linear_space)
  );

  // slot store; its read register is the data part of the output register
  rbf_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (PW),
    .DW    (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (s1_adv && ctrl_res.wr_en),
    .wr_addr (wr_addr),
    .wr_data (DATA_WIDTH'(s1_data)),
    .rd_en   (s1_adv && ctrl_res.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_status  <= ctrl_res.status;
      res_index   <= ctrl_res.index;
      res_data_ok <= ctrl_res.data_ok;
    end
  end

  assign out_valid = res_valid;
  assign status    = res_status;
  assign index     = res_index;
  // only a successful get shows a word
  assign data_out  = res_data_ok ? DATA_FIELD_W'(rd_data) : '0;

  // a refused put leaves the buffer full
  a_full_no_space: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_FULL |-> available == '0)
    else $error("put reported full but free space is not zero");

  // a refused get leaves the buffer empty
  a_empty_no_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_EMPTY |-> used == '0)
    else $error("get reported empty but buffer holds data");

  // a word only appears with a successful get
  a_data_only_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data_ok |-> res_status == ST_OK)
    else $error("data shown with a failing status");

  // an item leaving the input stage always lands in the output register
  a_stage_handover: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> res_valid)
    else $error("item lost between input and output register");

endmodule
